@@ hw/rtl/co2bcd_pkg.sv @@
package co2bcd_pkg;

    // Field widths
    localparam int SMP_W   = 16;
    localparam int PCT_W   = 7;
    localparam int CNT_W   = 16;
    localparam int TOT_W   = 32;
    localparam int EDGE_W  = 2;
    localparam int PROD_W  = SMP_W + PCT_W;

    // APB register map: one 32-bit word per register
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_RISE_PCT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FALL_PCT = 1'b1;

    localparam logic [PCT_W-1:0] RISE_PCT_RST = 7'd30;
    localparam logic [PCT_W-1:0] FALL_PCT_RST = 7'd30;

    // Percent scale used in the cross-multiplied threshold test
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_REPORT = 1'b1
    } t_op;

    typedef enum logic [EDGE_W-1:0] {
        EDGE_NONE   = 2'd0,
        EDGE_PEAK   = 2'd1,
        EDGE_TROUGH = 2'd2
    } t_edge;

endpackage

@@ hw/rtl/co2bcd_smp_if.sv @@
interface co2bcd_smp_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [co2bcd_pkg::SMP_W-1:0]   sample_ppm;

    modport source (output valid, output operation, output sample_ppm, input ready);
    modport sink   (input valid, input operation, input sample_ppm, output ready);
endinterface

@@ hw/rtl/co2bcd_res_if.sv @@
interface co2bcd_res_if;
    logic                           valid;
    logic                           ready;
    logic [co2bcd_pkg::EDGE_W-1:0]  edge_event;
    logic [co2bcd_pkg::CNT_W-1:0]   breath_count;
    logic [co2bcd_pkg::TOT_W-1:0]   co2_total;
    logic                           is_report;

    modport source (output valid, output edge_event, output breath_count,
                    output co2_total, output is_report, input ready);
    modport sink   (input valid, input edge_event, input breath_count,
                    input co2_total, input is_report, output ready);
endinterface

@@ hw/rtl/co2bcd_ram.sv @@
module co2bcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read-first: a read and write to the same address return the old data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/co2_breath_cycle_detector_core.sv @@
// CO2 breath cycle detector. Each sample transaction compares the newest stored
// sample with the one WINDOW_LEN-1 samples older (exact cross-multiplied percent
// test against rise_pct / fall_pct), marks a peak on a rise in the low phase and
// a trough on a fall in the high phase, and on a trough adds |peak - trough| to a
// saturating total and bumps a saturating breath count. Every transaction returns
// one result; a report transaction returns the totals and then clears them. The
// sample window sits in a circular buffer RAM; slots not yet written read as zero,
// and while the oldest sample is zero nothing is detected. Throughput is one
// transaction per cycle while the result output is not stalled. The RAM read of
// the oldest sample runs while the transaction sits in stage 1; the compare and
// update are then registered into the output register. rise_pct at byte address 0,
// fall_pct at 4; write them only while no transaction is in flight.
module co2_breath_cycle_detector_core #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    co2bcd_smp_if.sink                     i_smp,
    co2bcd_res_if.source                   o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [co2bcd_pkg::APB_AW-1:0]  paddr,
    input  logic [co2bcd_pkg::APB_DW-1:0]  pwdata,
    output logic [co2bcd_pkg::APB_DW-1:0]  prdata,
    output logic                           pready
);

    import co2bcd_pkg::*;

    localparam int             AW   = $clog2(WINDOW_LEN);
    localparam logic [AW-1:0]  LAST = AW'(WINDOW_LEN - 1);

    // Configuration
    logic [PCT_W-1:0]     r_rise_pct;
    logic [PCT_W-1:0]     r_fall_pct;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    // Window write side
    logic [AW-1:0]    r_wp;
    logic             r_full;
    logic [SMP_W-1:0] r_newest;
    logic [SMP_W-1:0] ram_q;

    // Stage 1 (RAM read in flight)
    logic             r_s1_valid;
    t_op              r_s1_op;
    logic [SMP_W-1:0] r_s1_newest;
    logic             r_s1_full;

    // Detector state
    logic             r_above;
    logic [SMP_W-1:0] r_peak;
    logic [CNT_W-1:0] r_tally;
    logic [TOT_W-1:0] r_acc;

    // Output register
    logic             r_o_valid;
    t_edge            r_o_edge;
    logic [CNT_W-1:0] r_o_count;
    logic [TOT_W-1:0] r_o_total;
    logic             r_o_report;

    // Handshake
    logic in_acc;
    logic smp_wr;
    logic out_free;
    logic s1_adv;

    // Stage 1 combinational results
    logic [SMP_W-1:0]  oldest;
    logic [SMP_W-1:0]  up_diff;
    logic [SMP_W-1:0]  dn_diff;
    logic [SMP_W-1:0]  pk_diff;
    logic [PROD_W-1:0] up_scaled;
    logic [PROD_W-1:0] dn_scaled;
    logic [PROD_W-1:0] rise_thr;
    logic [PROD_W-1:0] fall_thr;
    logic              rise;
    logic              fall;
    logic [TOT_W:0]    acc_sum;
    logic              n_above;
    logic [SMP_W-1:0]  n_peak;
    logic [CNT_W-1:0]  n_tally;
    logic [TOT_W-1:0]  n_acc;
    t_edge             n_edge;
    logic [CNT_W-1:0]  n_o_count;
    logic [TOT_W-1:0]  n_o_total;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1 -: REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_pct <= RISE_PCT_RST;
            r_fall_pct <= FALL_PCT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RISE_PCT: r_rise_pct <= pwdata[PCT_W-1:0];
                REG_FALL_PCT: r_fall_pct <= pwdata[PCT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RISE_PCT: prdata = APB_DW'(r_rise_pct);
            REG_FALL_PCT: prdata = APB_DW'(r_fall_pct);
            default:      prdata = '0;
        endcase
    end

    // Flow control: stage 1 moves when the output register is free; no input during reset
    assign out_free    = !r_o_valid || o_res.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_smp.ready = i_rst_n && (!r_s1_valid || out_free);
    assign in_acc      = i_smp.valid && i_smp.ready;
    assign smp_wr      = in_acc && (t_op'(i_smp.operation) == OP_SAMPLE);

    // Circular window: the slot about to be overwritten holds the oldest sample
    co2bcd_ram #(
        .WIDTH (SMP_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (smp_wr),
        .i_wr_addr (r_wp),
        .i_wr_data (i_smp.sample_ppm),
        .i_rd_en   (smp_wr),
        .i_rd_addr (r_wp),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_newest <= '0;
        end else if (smp_wr) begin
            r_wp     <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
            r_full   <= r_full || (r_wp == LAST);
            r_newest <= i_smp.sample_ppm;
        end
    end

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op     <= t_op'(i_smp.operation);
            r_s1_newest <= r_newest;
            r_s1_full   <= r_full;
        end
    end

    // Threshold tests, cross-multiplied
    assign oldest    = r_s1_full ? ram_q : '0;
    assign up_diff   = r_s1_newest - oldest;
    assign dn_diff   = oldest - r_s1_newest;
    assign up_scaled = PROD_W'(up_diff) * PROD_W'(PCT_SCALE);
    assign dn_scaled = PROD_W'(dn_diff) * PROD_W'(PCT_SCALE);
    assign rise_thr  = PROD_W'(r_rise_pct) * PROD_W'(oldest);
    assign fall_thr  = PROD_W'(r_fall_pct) * PROD_W'(oldest);
    assign rise      = (r_s1_newest > oldest) && (up_scaled > rise_thr);
    assign fall      = (oldest > r_s1_newest) && (dn_scaled > fall_thr);
    assign pk_diff   = (r_peak > oldest) ? r_peak - oldest : oldest - r_peak;
    assign acc_sum   = {1'b0, r_acc} + (TOT_W + 1)'(pk_diff);

    // Next state and result
    always_comb begin
        n_above   = r_above;
        n_peak    = r_peak;
        n_tally   = r_tally;
        n_acc     = r_acc;
        n_edge    = EDGE_NONE;
        n_o_count = r_tally;
        n_o_total = r_acc;
        case (r_s1_op)
            OP_REPORT: begin
                n_tally = '0;
                n_acc   = '0;
            end
            OP_SAMPLE: begin
                if (oldest != '0) begin
                    if (rise && !r_above) begin
                        n_peak  = oldest;
                        n_above = 1'b1;
                        n_edge  = EDGE_PEAK;
                    end else if (fall && r_above) begin
                        n_above = 1'b0;
                        n_edge  = EDGE_TROUGH;
                        n_acc   = acc_sum[TOT_W] ? '1 : acc_sum[TOT_W-1:0];
                        n_tally = (r_tally == '1) ? r_tally : r_tally + CNT_W'(1);
                    end
                end
                n_o_count = n_tally;
                n_o_total = n_acc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= 1'b0;
            r_peak  <= '0;
            r_tally <= '0;
            r_acc   <= '0;
        end else if (s1_adv) begin
            r_above <= n_above;
            r_peak  <= n_peak;
            r_tally <= n_tally;
            r_acc   <= n_acc;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_edge   <= n_edge;
            r_o_count  <= n_o_count;
            r_o_total  <= n_o_total;
            r_o_report <= (r_s1_op == OP_REPORT);
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.edge_event   = r_o_edge;
    assign o_res.breath_count = r_o_count;
    assign o_res.co2_total    = r_o_total;
    assign o_res.is_report    = r_o_report;

endmodule

@@ hw/rtl/co2bcd_checker.sv @@
module co2bcd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            i_ready,
    input logic [co2bcd_pkg::EDGE_W-1:0]   i_edge_event,
    input logic [co2bcd_pkg::CNT_W-1:0]    i_breath_count,
    input logic [co2bcd_pkg::TOT_W-1:0]    i_co2_total,
    input logic                            i_is_report
);

    import co2bcd_pkg::*;

    // A stalled result keeps valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_edge_event) && $stable(i_breath_count)
                                && $stable(i_co2_total) && $stable(i_is_report))
        else $error("result payload changed while stalled");

    // Report results never carry an edge
    a_report_no_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_report |-> i_edge_event == EDGE_NONE)
        else $error("report result carries an edge");

    // A trough completes a breath, so the count cannot be zero
    a_trough_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_is_report && i_edge_event == EDGE_TROUGH |-> i_breath_count != '0)
        else $error("trough reported with zero breath count");

    // Edge code is never the unused value
    a_edge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_edge_event == EDGE_NONE || i_edge_event == EDGE_PEAK
                    || i_edge_event == EDGE_TROUGH)
        else $error("unused edge code on result");

endmodule

bind co2_breath_cycle_detector_core co2bcd_checker u_co2bcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_edge_event   (o_res.edge_event),
    .i_breath_count (o_res.breath_count),
    .i_co2_total    (o_res.co2_total),
    .i_is_report    (o_res.is_report)
);
